### hdl/hspl_pkg.sv
// Package with word types, parser phases and character helpers for the status line parser.
`default_nettype none

package hspl_pkg;

    // One input word: a raw byte of the line and its last-byte flag.
    typedef struct packed {
        logic [7:0] line_byte;
        logic       end_of_line;
    } t_in_word;

    // One result word, given on the last byte of a line.
    typedef struct packed {
        logic        ok;
        logic [15:0] version;
        logic [15:0] status_code;
    } t_out_word;

    // Parser phases for the expected tokens of the line, plus a tail phase and a failed phase.
    typedef enum logic [3:0] {
        PH_H     = 4'd0,
        PH_T1    = 4'd1,
        PH_T2    = 4'd2,
        PH_P     = 4'd3,
        PH_SLASH = 4'd4,
        PH_MAJ0  = 4'd5,
        PH_MAJ   = 4'd6,
        PH_MIN0  = 4'd7,
        PH_MIN   = 4'd8,
        PH_SPACE = 4'd9,
        PH_STAT  = 4'd10,
        PH_TAIL  = 4'd11,
        PH_FAIL  = 4'd12
    } t_phase;

    // How far the version field has been parsed.
    localparam logic [1:0] VR_NONE  = 2'd0;
    localparam logic [1:0] VR_MAJOR = 2'd1;
    localparam logic [1:0] VR_MINOR = 2'd2;

    // Character constants.
    localparam logic [7:0] CASE_BIT   = 8'h20;
    localparam logic [7:0] CH_LOWER_H = 8'h68;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_P = 8'h70;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Decimal accumulate into 8 bits, saturating at 255.
    function automatic logic [7:0] acc8(input logic [7:0] v, input logic [7:0] c);
        logic [11:0] x;
        x = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {8'h00, c[3:0]};
        return (x > 12'd255) ? 8'hFF : x[7:0];
    endfunction

    // Decimal accumulate into 16 bits, saturating at 65535.
    function automatic logic [15:0] acc16(input logic [15:0] v, input logic [7:0] c);
        logic [19:0] x;
        x = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'h0000, c[3:0]};
        return (x > 20'd65535) ? 16'hFFFF : x[15:0];
    endfunction

endpackage

`default_nettype wire

### hdl/http_status_line_parser.sv
// Top level of the HTTP status line parser: input register, parser core, output register.
//
//  Channel | Direction | Handshake                  | Word
//  --------+-----------+----------------------------+----------------------------------
//  input   | in        | i_in_valid / o_in_ready    | i_in_word  (line_byte, end_of_line)
//  output  | out       | o_out_valid / i_out_ready  | o_out_word (ok, version, status_code)
//
//  One byte per cycle is sustained unless a last byte waits on a busy output register.
//  State steps once per byte; the result of a last byte is held in the output register.
//  Only last-byte words need the output register, so other bytes flow while a result waits.
//  i_rst_n is synchronous and active low; it returns the parser to the start of a line.
//  A stalled output blocks the input only when the next byte to process ends a line.
`default_nettype none

module http_status_line_parser (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire hspl_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output hspl_pkg::t_out_word      o_out_word
);

    logic                r_in_valid;
    hspl_pkg::t_in_word  r_in_word;
    hspl_pkg::t_out_word step_result;
    logic                out_free;
    logic                step_fire;
    logic                result_load;

    // A held byte advances unless it ends a line and the result slot is busy.
    assign step_fire   = r_in_valid && (!r_in_word.end_of_line || out_free);
    assign result_load = step_fire && r_in_word.end_of_line;
    assign o_in_ready  = !r_in_valid || step_fire;

    // Input register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
    end

    hspl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step_fire),
        .i_word   (r_in_word),
        .o_result (step_result)
    );

    hspl_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (result_load),
        .i_word  (step_result),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

    // Input is refused only while a byte is held and cannot advance.
    a_ready_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_in_word.end_of_line && o_out_valid))
        else $error("input stalled without cause");

    // A processed last byte shows up as a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result_load |=> o_out_valid)
        else $error("result missing after end of line");

    // A failed line never reports a status code.
    a_fail_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.ok) |-> (o_out_word.status_code == 16'h0000))
        else $error("status code reported for a failed line");

endmodule

`default_nettype wire

### hdl/hspl_core.sv
// Parser state registers and the per-byte step that updates them and forms the result.
`default_nettype none

module hspl_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire hspl_pkg::t_in_word i_word,
    output hspl_pkg::t_out_word     o_result
);

    hspl_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_major, n_major;
    logic [7:0]       r_minor, n_minor;
    logic [15:0]      r_status, n_status;
    logic [1:0]       r_reached, n_reached;

    logic [7:0] c;
    logic [7:0] lc;
    logic [1:0] fin_reached;
    logic       fin_ok;

    assign c  = i_word.line_byte;
    assign lc = c | hspl_pkg::CASE_BIT;

    // Next state for one byte of the line.
    always_comb begin
        n_phase   = r_phase;
        n_major   = r_major;
        n_minor   = r_minor;
        n_status  = r_status;
        n_reached = r_reached;
        unique case (r_phase)
            hspl_pkg::PH_H: begin
                n_phase = (lc == hspl_pkg::CH_LOWER_H) ? hspl_pkg::PH_T1 : hspl_pkg::PH_FAIL;
            end
            hspl_pkg::PH_T1: begin
                n_phase = (lc == hspl_pkg::CH_LOWER_T) ? hspl_pkg::PH_T2 : hspl_pkg::PH_FAIL;
            end
            hspl_pkg::PH_T2: begin
                n_phase = (lc == hspl_pkg::CH_LOWER_T) ? hspl_pkg::PH_P : hspl_pkg::PH_FAIL;
            end
            hspl_pkg::PH_P: begin
                n_phase = (lc == hspl_pkg::CH_LOWER_P) ? hspl_pkg::PH_SLASH
                                                       : hspl_pkg::PH_FAIL;
            end
            hspl_pkg::PH_SLASH: begin
                n_phase = (c == hspl_pkg::CH_SLASH) ? hspl_pkg::PH_MAJ0 : hspl_pkg::PH_FAIL;
            end
            hspl_pkg::PH_MAJ0: begin
                if (hspl_pkg::is_digit(c)) begin
                    n_major = hspl_pkg::acc8(8'h00, c);
                    n_phase = hspl_pkg::PH_MAJ;
                end else begin
                    n_phase = hspl_pkg::PH_FAIL;
                end
            end
            hspl_pkg::PH_MAJ: begin
                if (hspl_pkg::is_digit(c)) begin
                    n_major = hspl_pkg::acc8(r_major, c);
                end else begin
                    n_reached = hspl_pkg::VR_MAJOR;
                    n_phase   = (c == hspl_pkg::CH_DOT) ? hspl_pkg::PH_MIN0
                                                        : hspl_pkg::PH_FAIL;
                end
            end
            hspl_pkg::PH_MIN0: begin
                if (hspl_pkg::is_digit(c)) begin
                    n_minor = hspl_pkg::acc8(8'h00, c);
                    n_phase = hspl_pkg::PH_MIN;
                end else begin
                    n_phase = hspl_pkg::PH_FAIL;
                end
            end
            hspl_pkg::PH_MIN: begin
                if (hspl_pkg::is_digit(c)) begin
                    n_minor = hspl_pkg::acc8(r_minor, c);
                end else begin
                    n_reached = hspl_pkg::VR_MINOR;
                    n_phase   = hspl_pkg::is_space(c) ? hspl_pkg::PH_SPACE
                                                      : hspl_pkg::PH_FAIL;
                end
            end
            hspl_pkg::PH_SPACE: begin
                if (hspl_pkg::is_digit(c)) begin
                    n_status = hspl_pkg::acc16(16'h0000, c);
                    n_phase  = hspl_pkg::PH_STAT;
                end else if (!hspl_pkg::is_space(c)) begin
                    n_phase = hspl_pkg::PH_FAIL;
                end
            end
            hspl_pkg::PH_STAT: begin
                if (hspl_pkg::is_digit(c)) begin
                    n_status = hspl_pkg::acc16(r_status, c);
                end else begin
                    n_phase = hspl_pkg::PH_TAIL;
                end
            end
            hspl_pkg::PH_TAIL: begin
                n_phase = hspl_pkg::PH_TAIL;
            end
            default: begin
                n_phase = hspl_pkg::PH_FAIL;
            end
        endcase
    end

    // Result for a line that ends on this byte; digits still open count as reached.
    always_comb begin
        fin_reached = n_reached;
        if (n_phase == hspl_pkg::PH_MAJ) begin
            fin_reached = hspl_pkg::VR_MAJOR;
        end
        if (n_phase == hspl_pkg::PH_MIN) begin
            fin_reached = hspl_pkg::VR_MINOR;
        end
        fin_ok = (n_phase == hspl_pkg::PH_STAT) || (n_phase == hspl_pkg::PH_TAIL);
        o_result.ok               = fin_ok;
        o_result.version[15:8]    = (fin_reached >= hspl_pkg::VR_MAJOR) ? n_major : 8'h00;
        o_result.version[7:0]     = (fin_reached >= hspl_pkg::VR_MINOR) ? n_minor : 8'h00;
        o_result.status_code      = fin_ok ? n_status : 16'h0000;
    end

    // State registers; the last byte of a line returns them to the start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_word.end_of_line)) begin
            r_phase   <= hspl_pkg::PH_H;
            r_major   <= 8'h00;
            r_minor   <= 8'h00;
            r_status  <= 16'h0000;
            r_reached <= hspl_pkg::VR_NONE;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_major   <= n_major;
            r_minor   <= n_minor;
            r_status  <= n_status;
            r_reached <= n_reached;
        end
    end

    // The parser never leaves the valid range of phases.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= hspl_pkg::PH_FAIL)
        else $error("parser phase out of range");

    // After the last byte of a line the parser starts over.
    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_word.end_of_line)
            |=> (r_phase == hspl_pkg::PH_H && r_reached == hspl_pkg::VR_NONE))
        else $error("parser did not restart after end of line");

    // Once failed, the parser stays failed until the line ends.
    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_word.end_of_line && r_phase == hspl_pkg::PH_FAIL)
            |=> (r_phase == hspl_pkg::PH_FAIL))
        else $error("parser left the failed phase mid-line");

endmodule

`default_nettype wire

### hdl/hspl_out_buf.sv
// Output register that holds one result word until the consumer takes it.
`default_nettype none

module hspl_out_buf (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire hspl_pkg::t_out_word i_word,
    output logic                     o_free,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output hspl_pkg::t_out_word      o_word
);

    logic                r_valid;
    hspl_pkg::t_out_word r_word;

    // The slot can take a new word when empty or being emptied this cycle.
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    // A load never overwrites a word that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire
